@@ src/md4_pkg.sv @@
// ----------------------------------------------------------------------------
// MD4 package
// Shared constants, types and step tables for the MD4 digest block.
// ----------------------------------------------------------------------------
package md4_pkg;

    localparam logic [31:0] INIT_A   = 32'h67452301;
    localparam logic [31:0] INIT_B   = 32'hEFCDAB89;
    localparam logic [31:0] INIT_C   = 32'h98BADCFE;
    localparam logic [31:0] INIT_D   = 32'h10325476;
    localparam logic [31:0] ROUND2_K = 32'h5A827999;
    localparam logic [31:0] ROUND3_K = 32'h6ED9EBA1;

    localparam int unsigned STEP_COUNT = 48;

    typedef logic [3:0][31:0] chain_t;

    typedef struct packed {
        logic start;
        logic init;
    } core_ctrl_t;

    // Message word used by a given compression step.
    function automatic logic [3:0] msg_index(input logic [5:0] step);
        logic [3:0] pos;
        logic [3:0] idx;
        pos = step[3:0];
        case (step[5:4])
            2'd1:    idx = {pos[1:0], pos[3:2]};
            2'd2:    idx = {pos[0], pos[1], pos[2], pos[3]};
            default: idx = pos;
        endcase
        return idx;
    endfunction

    // Left rotation amount of a given compression step.
    function automatic logic [4:0] shift_amt(input logic [5:0] step);
        logic [4:0] s;
        case ({step[5:4], step[1:0]})
            4'b00_00: s = 5'd3;
            4'b00_01: s = 5'd7;
            4'b00_10: s = 5'd11;
            4'b00_11: s = 5'd19;
            4'b01_00: s = 5'd3;
            4'b01_01: s = 5'd5;
            4'b01_10: s = 5'd9;
            4'b01_11: s = 5'd13;
            4'b10_00: s = 5'd3;
            4'b10_01: s = 5'd9;
            4'b10_10: s = 5'd11;
            4'b10_11: s = 5'd15;
            default:  s = 5'd3;
        endcase
        return s;
    endfunction

    function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] tmp;
        tmp = {x, x} << n;
        return tmp[63:32];
    endfunction

endpackage

@@ src/md4_msg_ram.sv @@
// ----------------------------------------------------------------------------
// MD4 message RAM
// Sixteen-word block buffer with one write port and one registered read port.
// ----------------------------------------------------------------------------
module md4_msg_ram (
    input  logic        clk,
    input  logic        we,
    input  logic [3:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [3:0]  raddr,
    output logic [31:0] rdata
);

    logic [31:0] mem [16];
    logic [31:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ src/md4_core.sv @@
// ----------------------------------------------------------------------------
// MD4 compression core
// Runs the 48 steps of one block, one step per cycle, on words read from the
// block buffer, then folds the result into the chaining words.
// ----------------------------------------------------------------------------
module md4_core (
    input  logic               clk,
    input  logic               rst_n,
    input  md4_pkg::core_ctrl_t ctrl,
    output logic [3:0]         raddr,
    input  logic [31:0]        rdata,
    output md4_pkg::chain_t    chain,
    output logic               done
);

    import md4_pkg::*;

    chain_t      chain_reg;
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [5:0]  step_reg;
    logic        run_reg;
    logic        add_reg;

    logic [5:0]  cur_step;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] sum;
    logic [31:0] new_b;

    // The word for step n is requested while step n-1 is being computed.
    assign raddr    = msg_index(step_reg);
    assign cur_step = step_reg - 6'd1;

    always_comb
    begin
        case (cur_step[5:4])
            2'd0:
            begin
                f_val = (b_reg & c_reg) | (~b_reg & d_reg);
                k_val = 32'd0;
            end
            2'd1:
            begin
                f_val = (b_reg & c_reg) | (b_reg & d_reg) | (c_reg & d_reg);
                k_val = ROUND2_K;
            end
            default:
            begin
                f_val = b_reg ^ c_reg ^ d_reg;
                k_val = ROUND3_K;
            end
        endcase
        sum   = a_reg + f_val + rdata + k_val;
        new_b = rotl32(sum, shift_amt(cur_step));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= {INIT_D, INIT_C, INIT_B, INIT_A};
            step_reg  <= '0;
            run_reg   <= 1'b0;
            add_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.start)
            begin
                step_reg <= '0;
                run_reg  <= 1'b1;
            end
            else if (run_reg)
            begin
                step_reg <= step_reg + 6'd1;
                if (step_reg == 6'(STEP_COUNT))
                begin
                    run_reg <= 1'b0;
                    add_reg <= 1'b1;
                end
            end
            if (add_reg)
            begin
                add_reg      <= 1'b0;
                chain_reg[0] <= chain_reg[0] + a_reg;
                chain_reg[1] <= chain_reg[1] + b_reg;
                chain_reg[2] <= chain_reg[2] + c_reg;
                chain_reg[3] <= chain_reg[3] + d_reg;
            end
            else if (ctrl.init)
            begin
                chain_reg <= {INIT_D, INIT_C, INIT_B, INIT_A};
            end
        end
    end

    // Working variables rotate so that the updated word always lands in b;
    // after a multiple of four steps a..d line up with A..D again.
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a_reg <= chain_reg[0];
            b_reg <= chain_reg[1];
            c_reg <= chain_reg[2];
            d_reg <= chain_reg[3];
        end
        else if (run_reg && (step_reg != 6'd0))
        begin
            a_reg <= d_reg;
            b_reg <= new_b;
            c_reg <= b_reg;
            d_reg <= c_reg;
        end
    end

    assign chain = chain_reg;
    assign done  = add_reg;

endmodule

@@ src/md4_message_digest.sv @@
// ----------------------------------------------------------------------------
// MD4 message digest
// Byte-granular MD4 hashing of one message at a time, with padding and
// length append, delivering the four digest words on the output stream.
// ----------------------------------------------------------------------------
// The block takes a message as little-endian 32-bit words, up to four bytes
// per transaction, and returns the four MD4 digest words (A first) after the
// transaction marked tlast. An input transaction that completes a 64-byte
// block starts a compression, with the core doing one of the 48 steps per
// cycle against the single read port of the block RAM, followed by the final
// chaining add. The end of a message writes each padding word into the block
// RAM, runs one or two compressions, and presents four output transactions.
// While padding, compressing or presenting the digest, the input side is
// held off. No clearing pass is needed after reset.
// ----------------------------------------------------------------------------
module md4_message_digest (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // data_word[31:0], valid_bytes[34:32], zero[39:35]
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // digest_word[31:0]
    output logic [1:0]  m_axis_tuser,   // word_index[1:0]
    output logic        m_axis_tlast
);

    import md4_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD_FIRST,
        S_PAD_ZERO,
        S_COMP,
        S_OUT
    } state_t;

    // Mask covering the low cnt bytes of a word (cnt up to four).
    function automatic logic [31:0] byte_mask(input logic [2:0] cnt);
        logic [31:0] m;
        case (cnt)
            3'd0:    m = 32'h0000_0000;
            3'd1:    m = 32'h0000_00FF;
            3'd2:    m = 32'h0000_FFFF;
            3'd3:    m = 32'h00FF_FFFF;
            default: m = 32'hFFFF_FFFF;
        endcase
        return m;
    endfunction

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [31:0] acc_reg, acc_next;
    logic [63:0] len_reg, len_next;
    logic [3:0]  pad_idx_reg, pad_idx_next;
    logic        extra_reg, extra_next;
    logic [1:0]  oidx_reg, oidx_next;

    logic        in_fire;
    logic        out_fire;
    logic [2:0]  n_bytes;
    logic [2:0]  total;
    logic [63:0] combined;
    logic [31:0] partial;

    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;

    core_ctrl_t  core_ctrl;
    chain_t      chain;
    logic        core_done;

    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign out_fire = m_axis_tvalid && m_axis_tready;

    // A valid count above four counts as four.
    assign n_bytes = s_axis_tdata[34] ? 3'd4 : {1'b0, s_axis_tdata[33:32]};
    assign total   = {1'b0, fill_reg[1:0]} + n_bytes;

    // The held partial word keeps the bytes of the buffer word not yet full;
    // new bytes are placed right above them.
    assign partial  = acc_reg & byte_mask({1'b0, fill_reg[1:0]});
    assign combined = {32'd0, partial}
                    | ({32'd0, s_axis_tdata[31:0] & byte_mask(n_bytes)}
                       << {fill_reg[1:0], 3'b000});

    always_comb
    begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        fill_next    = fill_reg;
        acc_next     = acc_reg;
        len_next     = len_reg;
        pad_idx_next = pad_idx_reg;
        extra_next   = extra_reg;
        oidx_next    = oidx_reg;
        ram_we       = 1'b0;
        ram_waddr    = fill_reg[5:2];
        ram_wdata    = combined[31:0];
        core_ctrl    = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    ram_we    = total[2];
                    fill_next = fill_reg + {3'd0, n_bytes};
                    len_next  = len_reg + {58'd0, n_bytes, 3'b000};
                    acc_next  = total[2] ? combined[63:32] : combined[31:0];
                    if (total[2] && (fill_reg[5:2] == 4'd15))
                    begin
                        state_next     = S_COMP;
                        core_ctrl.start = 1'b1;
                        ret_next       = s_axis_tlast ? S_PAD_FIRST : S_IDLE;
                    end
                    else if (s_axis_tlast)
                    begin
                        state_next = S_PAD_FIRST;
                    end
                end
            end
            S_PAD_FIRST:
            begin
                // Closing byte 0x80 goes right after the last message byte.
                // In slot 14 it leaves no room for the length, so a zero-filled
                // block follows; in slot 15 it closes the block by itself.
                ram_we       = 1'b1;
                ram_wdata    = partial | (32'h0000_0080 << {fill_reg[1:0], 3'b000});
                pad_idx_next = fill_reg[5:2] + 4'd1;
                extra_next   = (fill_reg[5:2] == 4'd14);
                if (fill_reg[5:2] == 4'd15)
                begin
                    state_next      = S_COMP;
                    core_ctrl.start = 1'b1;
                    ret_next        = S_PAD_ZERO;
                end
                else
                begin
                    state_next = S_PAD_ZERO;
                end
            end
            S_PAD_ZERO:
            begin
                // The length words go into the last two slots of the final block
                // only; when the closing byte spilled past slot 13 this block
                // is zero-filled and one more block follows.
                ram_we       = 1'b1;
                ram_waddr    = pad_idx_reg;
                pad_idx_next = pad_idx_reg + 4'd1;
                if (!extra_reg && (pad_idx_reg == 4'd14))
                begin
                    ram_wdata = len_reg[31:0];
                end
                else if (!extra_reg && (pad_idx_reg == 4'd15))
                begin
                    ram_wdata = len_reg[63:32];
                end
                else
                begin
                    ram_wdata = 32'd0;
                end
                if (pad_idx_reg == 4'd15)
                begin
                    state_next      = S_COMP;
                    core_ctrl.start = 1'b1;
                    extra_next      = 1'b0;
                    ret_next        = extra_reg ? S_PAD_ZERO : S_OUT;
                end
            end
            S_COMP:
            begin
                if (core_done)
                begin
                    state_next = ret_reg;
                end
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    oidx_next = oidx_reg + 2'd1;
                    if (oidx_reg == 2'd3)
                    begin
                        core_ctrl.init = 1'b1;
                        fill_next      = '0;
                        len_next       = '0;
                        state_next     = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ret_reg     <= S_IDLE;
            fill_reg    <= '0;
            len_reg     <= '0;
            pad_idx_reg <= '0;
            extra_reg   <= 1'b0;
            oidx_reg    <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            ret_reg     <= ret_next;
            fill_reg    <= fill_next;
            len_reg     <= len_next;
            pad_idx_reg <= pad_idx_next;
            extra_reg   <= extra_next;
            oidx_reg    <= oidx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    md4_msg_ram u_msg_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    md4_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .chain (chain),
        .done  (core_done)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = chain[oidx_reg];
    assign m_axis_tuser  = oidx_reg;
    assign m_axis_tlast  = (oidx_reg == 2'd3);

endmodule
